// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the matcher.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define ENFA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen while out of reset.
`define ENFA_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/enfa_pkg.sv =====
// Shared types and constants of the epsilon-NFA stream matcher.
// Used by the table cells, the closure unit, the top level and the checker.
package enfa_pkg;

	localparam int NUM_STATES_DEF      = 16;
	localparam int MAX_TRANSITIONS_DEF = 64;

	// Four-bit state fields can name sixteen states at most.
	localparam int STATE_FIELD_RANGE = 16;
	localparam int SET_OUT_W         = 16;

	localparam logic [7:0] EPS_CODE_RESET = 8'd36;

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_APPEND  = 2'd1,
		FUNC_BEGIN   = 2'd2,
		FUNC_CONSUME = 2'd3
	} enfa_func_t;

	localparam logic [1:0] REG_START_STATE  = 2'd0;
	localparam logic [1:0] REG_FINAL_MASK   = 2'd1;
	localparam logic [1:0] REG_EPSILON_CODE = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] from_state;
		logic [7:0] symbol;
		logic [3:0] to_state;
	} enfa_in_t;

	typedef struct packed {
		logic [15:0] active_set;
		logic        accepted;
		logic        table_full;
	} enfa_out_t;

	typedef struct packed {
		logic [3:0] from_state;
		logic [7:0] symbol;
		logic [3:0] to_state;
	} enfa_entry_t;

	// Commands from the sequencer to the closure unit.
	typedef struct packed {
		logic       start;
		logic       clear;
		logic       add;
		logic [3:0] from_state;
		logic [3:0] to_state;
	} enfa_eps_cmd_t;

endpackage

// ===== sv/epsilon_nfa_stream_matcher.sv =====
// Epsilon-NFA stream matcher: each request (clear, append, begin word, consume symbol)
// returns one result with the epsilon-closed active set. One request is worked on at a
// time; a result register lets the next request enter while a result waits. Clear,
// append and begin run one epsilon closure of the set. Consume runs a closure of the
// current set, a scan in which the partial next set walks the chain of table cells
// one cell per cycle, then a closure of the new set.
module epsilon_nfa_stream_matcher
	import enfa_pkg::*;
#(
	parameter int NUM_STATES      = NUM_STATES_DEF,
	parameter int MAX_TRANSITIONS = MAX_TRANSITIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  enfa_in_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output enfa_out_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CntW  = $clog2(MAX_TRANSITIONS + 1);
	localparam int ScanW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
	localparam int ExtW  = (NUM_STATES > SET_OUT_W) ? NUM_STATES : SET_OUT_W;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_CLOS_SRC = 5'b00010,
		ST_SCAN     = 5'b00100,
		ST_NEXT     = 5'b01000,
		ST_CLOS_OUT = 5'b10000
	} state_t;

	state_t                state_q;
	logic [3:0]            start_state_q;
	logic [15:0]           final_mask_q;
	logic [7:0]            eps_code_q;
	logic [CntW-1:0]       count_q;
	logic [ScanW-1:0]      scan_cnt_q;
	logic [NUM_STATES-1:0] current_q;
	logic [7:0]            symbol_q;
	logic                  full_q;
	logic                  out_valid_q;
	enfa_out_t             out_q;

	logic                  take;
	logic                  cfg_wr;
	logic                  table_is_full;
	logic                  states_ok;
	logic                  append_ok;
	logic                  out_free;
	logic [NUM_STATES-1:0] begin_set;
	logic [NUM_STATES-1:0] seed;
	logic [NUM_STATES-1:0] closed_set;
	logic                  clos_done;
	logic [ExtW-1:0]       closed_ext;
	enfa_eps_cmd_t         eps_cmd;
	enfa_entry_t           wr_entry;
	logic [NUM_STATES-1:0] acc_chain [MAX_TRANSITIONS+1];

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			final_mask_q  <= '0;
			eps_code_q    <= EPS_CODE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_START_STATE:  start_state_q <= pwdata[3:0];
				REG_FINAL_MASK:   final_mask_q  <= pwdata[15:0];
				REG_EPSILON_CODE: eps_code_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START_STATE:  prdata = {28'd0, start_state_q};
			REG_FINAL_MASK:   prdata = {16'd0, final_mask_q};
			REG_EPSILON_CODE: prdata = {24'd0, eps_code_q};
			default:          prdata = '0;
		endcase
	end

	// Request decode
	assign take          = item_valid && (state_q == ST_IDLE);
	assign item_stall    = (state_q != ST_IDLE);
	assign table_is_full = (count_q == CntW'(MAX_TRANSITIONS));
	assign states_ok     = (32'(item.from_state) < 32'(NUM_STATES)) &&
	                       (32'(item.to_state) < 32'(NUM_STATES));
	assign append_ok     = take && (item.func == FUNC_APPEND) && !table_is_full && states_ok;
	assign out_free      = !out_valid_q || !result_stall;

	always_comb begin
		for (int s = 0; s < NUM_STATES; s++) begin
			begin_set[s] = (s < STATE_FIELD_RANGE) && (start_state_q == 4'(s));
		end
	end

	always_comb begin
		eps_cmd.start      = take || (state_q == ST_NEXT);
		eps_cmd.clear      = take && (item.func == FUNC_CLEAR);
		eps_cmd.add        = append_ok && (item.symbol == eps_code_q);
		eps_cmd.from_state = item.from_state;
		eps_cmd.to_state   = item.to_state;
		if (state_q == ST_NEXT) begin
			seed = acc_chain[MAX_TRANSITIONS];
		end else if (item.func == FUNC_BEGIN) begin
			seed = begin_set;
		end else begin
			seed = current_q;
		end
	end

	assign wr_entry.from_state = item.from_state;
	assign wr_entry.symbol     = item.symbol;
	assign wr_entry.to_state   = item.to_state;

	enfa_closure #(
		.NUM_STATES(NUM_STATES)
	) u_closure (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (eps_cmd),
		.seed      (seed),
		.closed_set(closed_set),
		.done      (clos_done)
	);

	// Chain of table cells; the partial next set enters empty at the head.
	assign acc_chain[0] = '0;

	for (genvar j = 0; j < MAX_TRANSITIONS; j++) begin : g_cell
		enfa_cell #(
			.NUM_STATES(NUM_STATES)
		) u_cell (
			.clk        (clk),
			.we         (append_ok && (count_q == CntW'(j))),
			.wr_entry   (wr_entry),
			.valid      (count_q > CntW'(j)),
			.scan_symbol(symbol_q),
			.src_set    (closed_set),
			.acc_in     (acc_chain[j]),
			.acc_out    (acc_chain[j+1])
		);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			current_q  <= '0;
			full_q     <= 1'b0;
			scan_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						full_q <= (item.func == FUNC_APPEND) && table_is_full;
						if (item.func == FUNC_CLEAR) begin
							count_q <= '0;
						end
						if (append_ok) begin
							count_q <= count_q + CntW'(1);
						end
						if (item.func == FUNC_BEGIN) begin
							current_q <= begin_set;
						end
						state_q <= (item.func == FUNC_CONSUME) ? ST_CLOS_SRC : ST_CLOS_OUT;
					end
				end
				ST_CLOS_SRC: begin
					if (clos_done) begin
						scan_cnt_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + ScanW'(1);
					if (scan_cnt_q == ScanW'(MAX_TRANSITIONS - 1)) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					current_q <= acc_chain[MAX_TRANSITIONS];
					state_q   <= ST_CLOS_OUT;
				end
				ST_CLOS_OUT: begin
					if (clos_done && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			symbol_q <= item.symbol;
		end
	end

	// Result register
	assign closed_ext = ExtW'(closed_set);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CLOS_OUT && clos_done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLOS_OUT && clos_done && out_free) begin
			out_q.active_set <= closed_ext[SET_OUT_W-1:0];
			out_q.accepted   <= |(closed_ext[SET_OUT_W-1:0] & final_mask_q);
			out_q.table_full <= full_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== sv/enfa_cell.sv =====
// One transition table entry of the matcher's cell chain.
// Depends on enfa_pkg; ORs its move into the set handed along the chain.
module enfa_cell
	import enfa_pkg::*;
#(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic                  clk,
	input  logic                  we,
	input  enfa_entry_t           wr_entry,
	input  logic                  valid,
	input  logic [7:0]            scan_symbol,
	input  logic [NUM_STATES-1:0] src_set,
	input  logic [NUM_STATES-1:0] acc_in,
	output logic [NUM_STATES-1:0] acc_out
);

	enfa_entry_t           entry_q;
	logic [NUM_STATES-1:0] acc_q;
	logic [NUM_STATES-1:0] move;
	logic                  src_hit;
	logic                  fire;

	always_comb begin
		src_hit = 1'b0;
		for (int s = 0; s < NUM_STATES; s++) begin
			if (s < STATE_FIELD_RANGE && entry_q.from_state == 4'(s)) begin
				src_hit = src_hit | src_set[s];
			end
		end
		fire = valid && src_hit && (entry_q.symbol == scan_symbol);
		for (int s = 0; s < NUM_STATES; s++) begin
			move[s] = fire && (s < STATE_FIELD_RANGE) && (entry_q.to_state == 4'(s));
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= wr_entry;
		end
		acc_q <= acc_in | move;
	end

	assign acc_out = acc_q;

endmodule

// ===== sv/enfa_closure.sv =====
// Epsilon edge matrix and iterative closure unit, one round per cycle.
// Depends on enfa_pkg; started and fed by the matcher's sequencer.
module enfa_closure
	import enfa_pkg::*;
#(
	parameter int NUM_STATES = NUM_STATES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  enfa_eps_cmd_t         cmd,
	input  logic [NUM_STATES-1:0] seed,
	output logic [NUM_STATES-1:0] closed_set,
	output logic                  done
);

	logic [NUM_STATES-1:0] rows_q [NUM_STATES];
	logic [NUM_STATES-1:0] work_q;
	logic [NUM_STATES-1:0] grown;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_STATES; r++) begin
				rows_q[r] <= '0;
			end
		end else if (cmd.clear) begin
			for (int r = 0; r < NUM_STATES; r++) begin
				rows_q[r] <= '0;
			end
		end else if (cmd.add) begin
			for (int r = 0; r < NUM_STATES; r++) begin
				for (int t = 0; t < NUM_STATES; t++) begin
					if (r < STATE_FIELD_RANGE && t < STATE_FIELD_RANGE &&
					    cmd.from_state == 4'(r) && cmd.to_state == 4'(t)) begin
						rows_q[r][t] <= 1'b1;
					end
				end
			end
		end
	end

	// One round: add every epsilon successor of the states held now.
	always_comb begin
		grown = work_q;
		for (int s = 0; s < NUM_STATES; s++) begin
			if (work_q[s]) begin
				grown = grown | rows_q[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			work_q <= seed;
		end else begin
			work_q <= grown;
		end
	end

	assign closed_set = work_q;
	assign done       = (grown == work_q);

endmodule

// ===== sv/enfa_checker.sv =====
// Port-level checker for the epsilon-NFA stream matcher, bound to the top level.
// Depends on enfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module enfa_checker
	import enfa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input enfa_out_t result
);

	// Hold a waiting result and its payload.
	`ENFA_ASSERT(a_result_hold, clk, arst_n, (result_valid && result_stall |=> result_valid && $stable(result)), "result dropped or changed while stalled")

	// One request at a time: stall right after a request is taken.
	`ENFA_ASSERT(a_stall_after_take, clk, arst_n, (item_valid && !item_stall |=> item_stall), "second request taken while one is in work")

	// An accepting result needs some active state.
	`ENFA_NEVER(a_accept_needs_state, clk, arst_n, (result_valid && result.accepted && (result.active_set == '0)), "accepted set with no active state")

endmodule

bind epsilon_nfa_stream_matcher enfa_checker u_enfa_checker (.*);
